FILE: rtl/sso_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sso_pkg
// Shared types and constants for the script signature-operation counter.
// ----------------------------------------------------------------------------
package sso_pkg;

  // Script length limit and derived position width
  localparam int MAX_SCRIPT_BYTES = 16384;
  localparam int POS_W            = $clog2(MAX_SCRIPT_BYTES + 1);

  // Result count width and saturation limit
  localparam int COUNT_W      = 19;
  localparam int MULTISIG_OPS = 20;
  localparam int CAP_RAW      = MAX_SCRIPT_BYTES * MULTISIG_OPS;
  localparam int COUNT_MAX    = (2 ** COUNT_W) - 1;
  localparam logic [COUNT_W-1:0] COUNT_CAP =
    COUNT_W'((CAP_RAW > COUNT_MAX) ? COUNT_MAX : CAP_RAW);

  // Width of one increment to the count (largest is the multisig default)
  localparam int ADD_W = 5;
  localparam logic [ADD_W-1:0] MULTISIG_DEFAULT = ADD_W'(MULTISIG_OPS);

  // Opcodes
  localparam logic [7:0] OP_FALSE         = 8'h00;
  localparam logic [7:0] OP_DIRECT_MAX    = 8'h4b;
  localparam logic [7:0] OP_PUSHDATA1     = 8'h4c;
  localparam logic [7:0] OP_PUSHDATA2     = 8'h4d;
  localparam logic [7:0] OP_PUSHDATA4     = 8'h4e;
  localparam logic [7:0] OP_SMALL_BASE    = 8'h50;
  localparam logic [7:0] OP_1             = 8'h51;
  localparam logic [7:0] OP_16            = 8'h60;
  localparam logic [7:0] OP_HASH160       = 8'ha9;
  localparam logic [7:0] OP_EQUAL         = 8'h87;
  localparam logic [7:0] OP_CHECKSIG      = 8'hac;
  localparam logic [7:0] OP_CHECKSIGVER   = 8'had;
  localparam logic [7:0] OP_CHECKMULTI    = 8'hae;
  localparam logic [7:0] OP_CHECKMULTIVER = 8'haf;
  localparam logic [7:0] OP_INVALID       = 8'hff;

  // Pay-to-script-hash pattern
  localparam logic [7:0]       P2SH_HASH_LEN = 8'h14;
  localparam logic [POS_W-1:0] P2SH_POS_LEN  = POS_W'(1);
  localparam logic [POS_W-1:0] P2SH_POS_LAST = POS_W'(22);

  // Parser phase
  typedef enum logic [1:0] {
    PH_OPCODE  = 2'd0,
    PH_LENGTH  = 2'd1,
    PH_PAYLOAD = 2'd2
  } phase_t;

  // Per-script result from parser to output register
  typedef struct packed {
    logic [COUNT_W-1:0] sigop_count;
    logic               push_only;
    logic               p2sh_form;
    logic               malformed;
  } result_t;

endpackage
`default_nettype wire

FILE: rtl/sso_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sso_parser
// Opcode walker: tracks pushes, counts signature operations and forms the
// script result on the final byte. State advances one byte per step.
// ----------------------------------------------------------------------------
module sso_parser (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             step,
  input  wire logic [7:0]       script_byte,
  input  wire logic             last_byte,
  input  wire logic             accurate_mode,
  output sso_pkg::result_t      result
);

  sso_pkg::phase_t                phase_r, phase_nxt;
  logic [2:0]                     left_r, left_nxt;
  logic [1:0]                     shift_r, shift_nxt;
  logic [31:0]                    rem_r, rem_nxt;
  logic [7:0]                     prev_r, prev_nxt;
  logic [sso_pkg::COUNT_W-1:0]    count_r, count_nxt;
  logic                           only_r, only_nxt;
  logic                           stop_r, stop_nxt;
  logic [sso_pkg::POS_W-1:0]      pos_r, pos_nxt;
  logic                           pm_r, pm_nxt;

  logic                           is_direct;
  logic                           is_pushdata;
  logic                           is_checksig;
  logic                           is_multi;
  logic                           prev_small;
  logic [sso_pkg::ADD_W-1:0]      add_n;
  logic                           add_en;
  logic [sso_pkg::COUNT_W:0]      sum;
  logic [31:0]                    len_part;
  logic [7:0]                     small_n;
  logic                           bad;

  // Decode the byte as an opcode
  always_comb begin
    is_direct   = (script_byte != sso_pkg::OP_FALSE) &&
                  (script_byte <= sso_pkg::OP_DIRECT_MAX);
    is_pushdata = (script_byte == sso_pkg::OP_PUSHDATA1) ||
                  (script_byte == sso_pkg::OP_PUSHDATA2) ||
                  (script_byte == sso_pkg::OP_PUSHDATA4);
    is_checksig = (script_byte == sso_pkg::OP_CHECKSIG) ||
                  (script_byte == sso_pkg::OP_CHECKSIGVER);
    is_multi    = (script_byte == sso_pkg::OP_CHECKMULTI) ||
                  (script_byte == sso_pkg::OP_CHECKMULTIVER);
    prev_small  = (prev_r >= sso_pkg::OP_1) && (prev_r <= sso_pkg::OP_16);
    small_n     = prev_r - sso_pkg::OP_SMALL_BASE;
    len_part    = {24'd0, script_byte} << {shift_r, 3'b000};
  end

  // Datapath update for one byte
  always_comb begin
    left_nxt  = left_r;
    shift_nxt = shift_r;
    rem_nxt   = rem_r;
    prev_nxt  = prev_r;
    only_nxt  = only_r;
    stop_nxt  = stop_r;
    pm_nxt    = pm_r;
    add_en    = 1'b0;
    add_n     = sso_pkg::MULTISIG_DEFAULT;

    // Pattern check on the first two bytes
    if ((pos_r == '0) && (script_byte != sso_pkg::OP_HASH160)) begin
      pm_nxt = 1'b0;
    end
    if ((pos_r == sso_pkg::P2SH_POS_LEN) && (script_byte != sso_pkg::P2SH_HASH_LEN)) begin
      pm_nxt = 1'b0;
    end

    if (!stop_r) begin
      case (phase_r)
        sso_pkg::PH_LENGTH: begin
          rem_nxt   = rem_r | len_part;
          shift_nxt = shift_r + 2'd1;
          if (left_r != 3'd0) begin
            left_nxt = left_r - 3'd1;
          end
        end
        sso_pkg::PH_PAYLOAD: begin
          if (rem_r != 32'd0) begin
            rem_nxt = rem_r - 32'd1;
          end
        end
        default: begin
          if (script_byte == sso_pkg::OP_INVALID) begin
            stop_nxt = 1'b1;
          end else begin
            if (script_byte > sso_pkg::OP_16) begin
              only_nxt = 1'b0;
            end
            if (is_direct) begin
              rem_nxt = {24'd0, script_byte};
            end else if (is_pushdata) begin
              case (script_byte)
                sso_pkg::OP_PUSHDATA1: left_nxt = 3'd1;
                sso_pkg::OP_PUSHDATA2: left_nxt = 3'd2;
                default:               left_nxt = 3'd4;
              endcase
              rem_nxt   = 32'd0;
              shift_nxt = 2'd0;
            end else if (is_checksig) begin
              add_en = 1'b1;
              add_n  = sso_pkg::ADD_W'(1);
            end else if (is_multi) begin
              add_en = 1'b1;
              if (accurate_mode && prev_small) begin
                add_n = small_n[sso_pkg::ADD_W-1:0];
              end
            end
            prev_nxt = script_byte;
          end
        end
      endcase
    end

    // Saturating count
    sum = {1'b0, count_r} + {{(sso_pkg::COUNT_W + 1 - sso_pkg::ADD_W){1'b0}}, add_n};
    if (!add_en) begin
      count_nxt = count_r;
    end else if (sum > {1'b0, sso_pkg::COUNT_CAP}) begin
      count_nxt = sso_pkg::COUNT_CAP;
    end else begin
      count_nxt = sum[sso_pkg::COUNT_W-1:0];
    end

    // Saturating byte position
    if (pos_r < sso_pkg::POS_W'(sso_pkg::MAX_SCRIPT_BYTES)) begin
      pos_nxt = pos_r + sso_pkg::POS_W'(1);
    end else begin
      pos_nxt = pos_r;
    end
  end

  // Next parse phase
  always_comb begin
    phase_nxt = phase_r;
    if (!stop_r) begin
      case (phase_r)
        sso_pkg::PH_LENGTH: begin
          if (left_nxt == 3'd0) begin
            phase_nxt = (rem_nxt != 32'd0) ? sso_pkg::PH_PAYLOAD : sso_pkg::PH_OPCODE;
          end
        end
        sso_pkg::PH_PAYLOAD: begin
          if (rem_nxt == 32'd0) begin
            phase_nxt = sso_pkg::PH_OPCODE;
          end
        end
        default: begin
          if (script_byte == sso_pkg::OP_INVALID) begin
            phase_nxt = sso_pkg::PH_OPCODE;
          end else if (is_direct) begin
            phase_nxt = sso_pkg::PH_PAYLOAD;
          end else if (is_pushdata) begin
            phase_nxt = sso_pkg::PH_LENGTH;
          end else begin
            phase_nxt = sso_pkg::PH_OPCODE;
          end
        end
      endcase
    end
  end

  // Script result as seen after this byte
  always_comb begin
    bad                = stop_nxt || (phase_nxt != sso_pkg::PH_OPCODE);
    result.sigop_count = count_nxt;
    result.push_only   = only_nxt && !bad;
    result.p2sh_form   = pm_nxt && (pos_r == sso_pkg::P2SH_POS_LAST) &&
                         (script_byte == sso_pkg::OP_EQUAL);
    result.malformed   = bad;
  end

  // Advance on each byte; start over after the final byte
  always_ff @(posedge clk) begin
    if (!rst_n || (step && last_byte)) begin
      phase_r <= sso_pkg::PH_OPCODE;
      left_r  <= 3'd0;
      shift_r <= 2'd0;
      rem_r   <= 32'd0;
      prev_r  <= sso_pkg::OP_INVALID;
      count_r <= '0;
      only_r  <= 1'b1;
      stop_r  <= 1'b0;
      pos_r   <= '0;
      pm_r    <= 1'b1;
    end else if (step) begin
      phase_r <= phase_nxt;
      left_r  <= left_nxt;
      shift_r <= shift_nxt;
      rem_r   <= rem_nxt;
      prev_r  <= prev_nxt;
      count_r <= count_nxt;
      only_r  <= only_nxt;
      stop_r  <= stop_nxt;
      pos_r   <= pos_nxt;
      pm_r    <= pm_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/script_sigop_counter.sv
// Path: a final byte is held in the input register, the parser works on it
// combinationally, and its result is captured into the result register and
// shown on out_* until it is taken.
// Throughput: one script byte per cycle, set by the phase update of the parser
// state; a final byte waits only while an earlier result stalls.
// Reset: synchronous, active low; clears the parser and both stages and sets
// accurate mode to 1.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// script_sigop_counter
// Streams script bytes, counts legacy signature operations and reports the
// count with push-only, pay-to-script-hash and malformed flags per script.
// ----------------------------------------------------------------------------
module script_sigop_counter (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [7:0]                  in_script_byte,
  input  wire logic                        in_last_byte,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [sso_pkg::COUNT_W-1:0]      out_sigop_count,
  output logic                             out_push_only,
  output logic                             out_p2sh_form,
  output logic                             out_malformed,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic                        cfg_data
);

  logic             s0_valid_r, s0_valid_nxt;
  logic [7:0]       s0_byte_r;
  logic             s0_last_r;
  logic             step;
  logic             in_take;
  logic             out_valid_r, out_valid_nxt;
  logic             acc_r;
  sso_pkg::result_t res;
  sso_pkg::result_t out_r;

  // Advance the held byte unless its result has nowhere to go
  always_comb begin
    step          = s0_valid_r && (!s0_last_r || !out_valid_r || !out_stall);
    in_stall      = s0_valid_r && !step;
    in_take       = in_valid && !in_stall;
    s0_valid_nxt  = in_take || (s0_valid_r && !step);
    out_valid_nxt = (step && s0_last_r) || (out_valid_r && out_stall);
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else begin
      s0_valid_r <= s0_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s0_byte_r <= in_script_byte;
      s0_last_r <= in_last_byte;
    end
  end

  // Configuration register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      acc_r <= cfg_data;
    end
  end

  sso_parser u_parser (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (step),
    .script_byte   (s0_byte_r),
    .last_byte     (s0_last_r),
    .accurate_mode (acc_r),
    .result        (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step && s0_last_r) begin
      out_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_sigop_count = out_r.sigop_count;
  assign out_push_only   = out_r.push_only;
  assign out_p2sh_form   = out_r.p2sh_form;
  assign out_malformed   = out_r.malformed;

endmodule
`default_nettype wire

FILE: rtl/sso_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sso_checker
// Port-level checks on the script signature-operation counter results.
// ----------------------------------------------------------------------------
module sso_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        out_valid,
  input wire logic                        out_stall,
  input wire logic [sso_pkg::COUNT_W-1:0] out_sigop_count,
  input wire logic                        out_push_only,
  input wire logic                        out_p2sh_form,
  input wire logic                        out_malformed
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_sigop_count) &&
      $stable(out_push_only) && $stable(out_p2sh_form) && $stable(out_malformed))
    else $error("stalled result changed");

  // Drop results across reset
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A malformed script is never push-only
  a_bad_not_push: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_malformed |-> !out_push_only)
    else $error("malformed script flagged push-only");

  // The hash-script pattern parses cleanly with no signature operations
  a_p2sh_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_p2sh_form |-> !out_malformed && !out_push_only &&
      (out_sigop_count == '0))
    else $error("hash-script pattern result inconsistent");

  // Count stays within its saturation limit
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_sigop_count <= sso_pkg::COUNT_CAP)
    else $error("count above saturation limit");

endmodule

bind script_sigop_counter sso_checker u_sso_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_sigop_count (out_sigop_count),
  .out_push_only   (out_push_only),
  .out_p2sh_form   (out_p2sh_form),
  .out_malformed   (out_malformed)
);
`default_nettype wire

FILE: tb/tb_script_sigop_counter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_script_sigop_counter
// Streams scripts into the signature-operation counter and scores every
// per-script report against a cycle-free predictor. Covers directed corner
// scripts, random well-formed, truncated, invalid and pay-to-script-hash
// shaped scripts, both accounting modes, and random idling on both channels.
// ----------------------------------------------------------------------------
module tb_script_sigop_counter;
  import sso_pkg::*;

  // Opcodes the package does not name
  localparam logic [7:0] OP_1NEGATE = 8'h4f;
  localparam logic [7:0] OP_NOP     = 8'h61;

  // Count saturation point
  localparam int SIGOP_LIMIT =
    (MAX_SCRIPT_BYTES * MULTISIG_OPS > (2 ** COUNT_W) - 1) ?
    (2 ** COUNT_W) - 1 : MAX_SCRIPT_BYTES * MULTISIG_OPS;

  // Predicts one report per script and checks reports in order
  class sigop_scoreboard;
    bit              accurate;
    phase_t          phase;
    int              len_left;
    bit [31:0]       push_left;
    logic [7:0]      prev_op;
    int              ops;
    bit              pushes_only;
    bit              halted;
    int              pos;
    bit              hdr_ok;
    int              len_shift;
    result_t         script_reports[$];
    int              errors;

    function new();
      accurate = 1'b1;
      errors   = 0;
      restart();
    endfunction

    function void restart();
      phase       = PH_OPCODE;
      len_left    = 0;
      push_left   = '0;
      prev_op     = OP_INVALID;
      ops         = 0;
      pushes_only = 1'b1;
      halted      = 1'b0;
      pos         = 0;
      hdr_ok      = 1'b1;
      len_shift   = 0;
    endfunction

    function void set_mode(logic m);
      accurate = m;
    endfunction

    function int pending();
      return script_reports.size();
    endfunction

    function void add_ops(int n);
      ops = (ops + n > SIGOP_LIMIT) ? SIGOP_LIMIT : ops + n;
    endfunction

    // Decode one byte in opcode position
    function void take_op(logic [7:0] op);
      if (op == OP_INVALID) begin
        halted = 1'b1;
        return;
      end
      if (op > OP_16) pushes_only = 1'b0;
      if (op != OP_FALSE && op <= OP_DIRECT_MAX) begin
        push_left = 32'(op);
        phase     = PH_PAYLOAD;
      end else if (op >= OP_PUSHDATA1 && op <= OP_PUSHDATA4) begin
        len_left  = (op == OP_PUSHDATA1) ? 1 : (op == OP_PUSHDATA2) ? 2 : 4;
        push_left = '0;
        len_shift = 0;
        phase     = PH_LENGTH;
      end else if (op == OP_CHECKSIG || op == OP_CHECKSIGVER) begin
        add_ops(1);
      end else if (op == OP_CHECKMULTI || op == OP_CHECKMULTIVER) begin
        if (accurate && prev_op >= OP_1 && prev_op <= OP_16)
          add_ops(int'(prev_op) - int'(OP_SMALL_BASE));
        else
          add_ops(MULTISIG_OPS);
      end
      prev_op = op;
    endfunction

    // Advance the predictor by one accepted request
    function void note_byte(logic [7:0] b, logic last);
      int      at;
      bit      bad;
      result_t r;
      at = pos;
      if (at == 0 && b != OP_HASH160) hdr_ok = 1'b0;
      if (at == int'(P2SH_POS_LEN) && b != P2SH_HASH_LEN) hdr_ok = 1'b0;
      if (!halted) begin
        case (phase)
          PH_LENGTH: begin
            if (len_shift < 32) push_left |= 32'(b) << len_shift;
            len_shift += 8;
            if (len_left > 0) len_left--;
            if (len_left == 0) phase = (push_left != 0) ? PH_PAYLOAD : PH_OPCODE;
          end
          PH_PAYLOAD: begin
            if (push_left > 0) push_left--;
            if (push_left == 0) phase = PH_OPCODE;
          end
          default: begin
            phase = PH_OPCODE;
            take_op(b);
          end
        endcase
      end
      if (pos < MAX_SCRIPT_BYTES) pos++;
      if (last) begin
        bad           = halted || phase != PH_OPCODE;
        r.sigop_count = COUNT_W'(ops);
        r.push_only   = pushes_only && !bad;
        r.p2sh_form   = hdr_ok && at == int'(P2SH_POS_LAST) && b == OP_EQUAL;
        r.malformed   = bad;
        script_reports.push_back(r);
        restart();
      end
    endfunction

    function void compare_field(string name, int want, int got);
      if (want != got) begin
        $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    // Compare one accepted report with the oldest prediction
    function void check_result(logic [COUNT_W-1:0] cnt, logic po, logic p2, logic mal);
      result_t want;
      if (script_reports.size() == 0) begin
        $display("%0t: report with none expected, expected none actual count %0d",
                 $time, cnt);
        errors++;
        return;
      end
      want = script_reports.pop_front();
      compare_field("sigop_count", want.sigop_count, cnt);
      compare_field("push_only", want.push_only, po);
      compare_field("p2sh_form", want.p2sh_form, p2);
      compare_field("malformed", want.malformed, mal);
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [7:0]         in_script_byte = '0;
  logic               in_last_byte = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [COUNT_W-1:0] out_sigop_count;
  logic               out_push_only;
  logic               out_p2sh_form;
  logic               out_malformed;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic               cfg_data = 1'b0;

  sigop_scoreboard sb;
  int              src_idle_pct = 0;
  int              sink_idle_pct = 0;
  logic [7:0]      script_q[$];

  script_sigop_counter u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_script_byte  (in_script_byte),
    .in_last_byte    (in_last_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_sigop_count (out_sigop_count),
    .out_push_only   (out_push_only),
    .out_p2sh_form   (out_p2sh_form),
    .out_malformed   (out_malformed),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data)
  );

  always #10 clk = ~clk;

  // Take reports and throttle the result channel
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_sigop_count, out_push_only, out_p2sh_form, out_malformed);
    out_stall <= ($urandom_range(99) < sink_idle_pct);
  end

  // Send one byte request, idling at random first
  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_script_byte <= b;
    in_last_byte   <= last;
    do @(posedge clk); while (in_stall);
    sb.note_byte(b, last);
  endtask

  task automatic send_script();
    for (int i = 0; i < script_q.size(); i++)
      send_byte(script_q[i], i == script_q.size() - 1);
    script_q.delete();
  endtask

  // Wait for all reports, then let the pipeline settle
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_mode(input logic m);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    do @(posedge clk); while (!cfg_ready);
    sb.set_mode(m);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  // Append a complete push with random payload
  function automatic void add_push();
    int n;
    n = $urandom_range(0, 12);
    case ($urandom_range(0, 3))
      0: begin
        n = $urandom_range(1, 12);
        if ($urandom_range(0, 9) == 0) n = $urandom_range(13, OP_DIRECT_MAX);
        script_q.push_back(8'(n));
      end
      1: begin
        script_q.push_back(OP_PUSHDATA1);
        script_q.push_back(8'(n));
      end
      2: begin
        if ($urandom_range(0, 9) == 0) n = $urandom_range(250, 300);
        script_q.push_back(OP_PUSHDATA2);
        script_q.push_back(8'(n));
        script_q.push_back(8'(n >> 8));
      end
      default: begin
        script_q.push_back(OP_PUSHDATA4);
        script_q.push_back(8'(n));
        repeat (3) script_q.push_back(8'h00);
      end
    endcase
    repeat (n) script_q.push_back(rand_byte());
  endfunction

  // Append a push that the end of the script cuts short
  function automatic void add_cut_push();
    int n;
    case ($urandom_range(0, 2))
      0: begin
        n = $urandom_range(2, OP_DIRECT_MAX);
        script_q.push_back(8'(n));
        repeat ($urandom_range(0, (n > 20) ? 19 : n - 1)) script_q.push_back(rand_byte());
      end
      1: begin
        script_q.push_back(OP_PUSHDATA4);
        repeat ($urandom_range(0, 3)) script_q.push_back(rand_byte());
      end
      default: begin
        n = $urandom_range(1, 255);
        script_q.push_back(OP_PUSHDATA2);
        script_q.push_back(8'(n));
        script_q.push_back(8'h00);
        repeat ($urandom_range(0, (n > 20) ? 19 : n - 1)) script_q.push_back(rand_byte());
      end
    endcase
  endfunction

  // Append a run of well-formed opcodes
  function automatic void add_ops_run();
    repeat ($urandom_range(1, 8)) begin
      case ($urandom_range(0, 9))
        0: begin
          case ($urandom_range(0, 3))
            0:       script_q.push_back(OP_FALSE);
            1:       script_q.push_back(OP_1NEGATE);
            2:       script_q.push_back(OP_SMALL_BASE);
            default: script_q.push_back(8'(OP_1 + $urandom_range(0, 15)));
          endcase
        end
        1, 2: add_push();
        3: script_q.push_back($urandom_range(0, 1) ? OP_CHECKSIG : OP_CHECKSIGVER);
        4, 5: begin
          script_q.push_back(8'(OP_1 + $urandom_range(0, 15)));
          script_q.push_back($urandom_range(0, 1) ? OP_CHECKMULTI : OP_CHECKMULTIVER);
        end
        6: script_q.push_back(8'($urandom_range(OP_NOP, OP_INVALID - 1)));
        7: script_q.push_back($urandom_range(0, 1) ? OP_CHECKMULTI : OP_CHECKMULTIVER);
        default: add_push();
      endcase
    end
  endfunction

  // Build one random script of a random shape
  function automatic void build_random_script();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      add_ops_run();
    end else if (pick < 65) begin
      script_q.push_back(OP_HASH160);
      script_q.push_back(P2SH_HASH_LEN);
      repeat (20) script_q.push_back(rand_byte());
      script_q.push_back(OP_EQUAL);
      // corrupt the pattern now and then
      if ($urandom_range(0, 3) == 0) begin
        case ($urandom_range(0, 2))
          0:       script_q[$urandom_range(0, 22)] = rand_byte();
          1:       script_q.push_back(rand_byte());
          default: void'(script_q.pop_back());
        endcase
      end
    end else if (pick < 75) begin
      if ($urandom_range(0, 1)) add_ops_run();
      add_cut_push();
    end else if (pick < 85) begin
      if ($urandom_range(0, 1)) add_ops_run();
      script_q.push_back(OP_INVALID);
      repeat ($urandom_range(0, 5)) script_q.push_back(rand_byte());
    end else begin
      repeat ($urandom_range(1, 30)) script_q.push_back(rand_byte());
    end
  endfunction

  task automatic run_random(input int n_bytes, input int src_pct, input int sink_pct);
    int sent;
    sent          = 0;
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
    while (sent < n_bytes) begin
      build_random_script();
      sent += script_q.size();
      send_script();
    end
  endtask

  initial begin
    sb = new();
    src_idle_pct  = 13;
    sink_idle_pct = 67;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed scripts in accurate mode (reset value)
    script_q = '{OP_CHECKSIG};                              send_script();
    script_q = '{OP_FALSE};                                 send_script();
    script_q = '{8'(OP_1 + 2), OP_CHECKMULTI};              send_script();
    script_q = '{OP_16, OP_CHECKMULTIVER};                  send_script();
    script_q = '{OP_SMALL_BASE, OP_CHECKMULTI};             send_script();
    // zero-length pushes are valid and empty
    script_q = '{OP_PUSHDATA1, 8'h00, OP_CHECKSIGVER};      send_script();
    script_q = '{OP_PUSHDATA2, 8'h00, 8'h00};               send_script();
    // truncated length, invalid opcode, truncated payload
    script_q = '{OP_PUSHDATA4};                             send_script();
    script_q = '{OP_INVALID, OP_CHECKSIG};                  send_script();
    script_q = '{8'h02, OP_INVALID};                        send_script();

    // Multisig always counts the default in fixed mode
    write_mode(1'b0);
    script_q = '{8'(OP_1 + 1), OP_CHECKMULTI};              send_script();

    write_mode(1'b1);
    run_random(300, 13, 67);
    write_mode(1'b0);
    run_random(300, 67, 13);
    write_mode(1'b1);
    run_random(300, 0, 0);

    drain();
    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("tb_script_sigop_counter OK");
    end else begin
      $display("tb_script_sigop_counter NOT OK");
    end
    $finish;
  end

  // Hard stop for a hung run
  initial begin
    #20_000_000;
    $display("tb_script_sigop_counter NOT OK");
    $finish;
  end

endmodule

FILE: sim.f
rtl/sso_pkg.sv
rtl/sso_parser.sv
rtl/script_sigop_counter.sv
rtl/sso_checker.sv
tb/tb_script_sigop_counter.sv
